@@ design/mh2_pkg.sv @@
// ----------------------------------------------------------------------------
// MurmurHash2 stream hasher package
// Shared constants, command types and state encodings for the hasher.
// ----------------------------------------------------------------------------
package mh2_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned CountW     = 3;
  localparam int unsigned MixShift   = 24;
  localparam int unsigned FinShiftA  = 13;
  localparam int unsigned FinShiftB  = 15;
  localparam int unsigned QueueDepth = 2;

  localparam logic [WordW-1:0]  MixMul    = 32'h5bd1e995;
  localparam logic [CountW-1:0] FullCount = 3'd4;

  // How the back end treats one queued request.
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_TAIL,
    KIND_WORD
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic             first;
    logic             close;
    logic [WordW-1:0] word;
    logic [WordW-1:0] hinit;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_K2,
    ST_HMUL,
    ST_TAIL,
    ST_FIN
  } back_state_e;

  function automatic logic [WordW-1:0] tail_mask(input logic [1:0] nbytes);
    logic [WordW-1:0] mask;
    case (nbytes)
      2'd1:    mask = 32'h0000_00ff;
      2'd2:    mask = 32'h0000_ffff;
      2'd3:    mask = 32'h00ff_ffff;
      default: mask = '0;
    endcase
    return mask;
  endfunction

endpackage

@@ design/mh2_if.sv @@
// ----------------------------------------------------------------------------
// MurmurHash2 channel interfaces
// Valid/ready channels for message words in and finished hashes out.
// ----------------------------------------------------------------------------
interface mh2_in_if;
  logic                          valid;
  logic                          ready;
  logic [mh2_pkg::WordW-1:0]     data_word;
  logic [mh2_pkg::CountW-1:0]    byte_count;
  logic                          first_item;
  logic                          last_item;
  logic [mh2_pkg::WordW-1:0]     message_length;

  modport source (
    output valid, data_word, byte_count, first_item, last_item, message_length,
    input  ready
  );
  modport sink (
    input  valid, data_word, byte_count, first_item, last_item, message_length,
    output ready
  );
endinterface

interface mh2_out_if;
  logic                      valid;
  logic                      ready;
  logic [mh2_pkg::WordW-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

@@ design/mh2_front.sv @@
// ----------------------------------------------------------------------------
// MurmurHash2 front end
// Holds the seed, tracks message framing, drops stray items and classifies
// each kept item into a request for the back end.
// ----------------------------------------------------------------------------
module mh2_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mh2_pkg::WordW-1:0] cfg_wdata_i,
  mh2_in_if.sink                    item_i,
  output mh2_pkg::cmd_t             cmd_o,
  output logic                      cmd_push_o,
  input  logic                      cmd_full_i
);
  import mh2_pkg::*;

  logic [WordW-1:0] seed_q, seed_d;
  logic             open_q, open_d;
  logic             accept;
  logic             full_word;
  logic             close;
  logic             keep;

  assign item_i.ready = !cmd_full_i;
  assign accept       = item_i.valid && item_i.ready;

  // Counts of four and above are taken as a full word.
  assign full_word = (item_i.byte_count >= FullCount);
  assign close     = !full_word || item_i.last_item;
  assign keep      = item_i.first_item || open_q;

  always_comb begin
    seed_d = seed_q;
    if (cfg_we_i) begin
      seed_d = cfg_wdata_i;
    end
    open_d = open_q;
    if (accept && keep) begin
      open_d = !close;
    end
  end

  always_comb begin
    cmd_o.first = item_i.first_item;
    cmd_o.close = close;
    cmd_o.hinit = seed_q ^ item_i.message_length;
    if (full_word) begin
      cmd_o.kind = KIND_WORD;
      cmd_o.word = item_i.data_word;
    end else if (item_i.byte_count == '0) begin
      cmd_o.kind = KIND_NONE;
      cmd_o.word = '0;
    end else begin
      cmd_o.kind = KIND_TAIL;
      cmd_o.word = item_i.data_word & tail_mask(item_i.byte_count[1:0]);
    end
  end

  assign cmd_push_o = accept && keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      open_q <= 1'b0;
    end else begin
      seed_q <= seed_d;
      open_q <= open_d;
    end
  end

endmodule

@@ design/mh2_queue.sv @@
// ----------------------------------------------------------------------------
// MurmurHash2 request queue
// Small FIFO that decouples the front end from the mixing back end.
// ----------------------------------------------------------------------------
module mh2_queue #(
  parameter int unsigned Depth = mh2_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mh2_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output mh2_pkg::cmd_t head_o,
  output logic          nonempty_o
);
  import mh2_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ design/mh2_back.sv @@
// ----------------------------------------------------------------------------
// MurmurHash2 back end
// Sequencer around one shared 32-bit multiplier that premixes words, folds
// them into the running hash, mixes tails, finalizes and holds the result.
// ----------------------------------------------------------------------------
module mh2_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mh2_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  mh2_out_if.source     result_o
);
  import mh2_pkg::*;

  back_state_e      state_q, state_d;
  logic [WordW-1:0] h_q, h_d;
  logic [WordW-1:0] t_q, t_d;
  logic             close_q, close_d;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] out_hash_q, out_hash_d;
  logic [WordW-1:0] mul_a;
  logic [WordW-1:0] product;

  // Only the low word of the product is kept.
  assign product = mul_a * MixMul;

  always_comb begin
    state_d     = state_q;
    h_d         = h_q;
    t_d         = t_q;
    close_d     = close_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_hash_d  = out_hash_q;
    cmd_pop_o   = 1'b0;
    mul_a       = '0;
    case (state_q)
      ST_IDLE: begin
        mul_a = cmd_i.word;
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          close_d   = cmd_i.close;
          if (cmd_i.first) begin
            h_d = cmd_i.hinit;
          end
          case (cmd_i.kind)
            KIND_WORD: begin
              t_d     = product;
              state_d = ST_K2;
            end
            KIND_TAIL: begin
              t_d     = cmd_i.word;
              state_d = ST_TAIL;
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end
      ST_K2: begin
        mul_a   = t_q ^ (t_q >> MixShift);
        t_d     = product;
        state_d = ST_HMUL;
      end
      ST_HMUL: begin
        mul_a   = h_q;
        h_d     = product ^ t_q;
        state_d = close_q ? ST_FIN : ST_IDLE;
      end
      ST_TAIL: begin
        mul_a   = h_q ^ t_q;
        h_d     = product;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        mul_a = h_q ^ (h_q >> FinShiftA);
        // Waits here while the previous result is still held.
        if (!out_valid_d) begin
          out_valid_d = 1'b1;
          out_hash_d  = product ^ (product >> FinShiftB);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.hash_value = out_hash_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q        <= h_d;
    t_q        <= t_d;
    close_q    <= close_d;
    out_hash_q <= out_hash_d;
  end

endmodule

@@ design/murmurhash2_32.sv @@
// ----------------------------------------------------------------------------
// MurmurHash2 32-bit stream hasher
// Hashes a message streamed as little-endian 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   item_i carries one message word per request with its byte count and the
//   first/last markers; the first request also carries the message length.
//   A request with fewer than four bytes closes the message. Requests that
//   arrive while no message is open and are not marked first are dropped.
//   result_o delivers one finalized hash per message. The seed is written by
//   the user through cfg_we_i/cfg_wdata_i while the block is idle (unchecked).
// Sequencing:
//   All mixing runs through a single 32x32 multiplier, so the back end works
//   on one request at a time: a full word passes ST_IDLE, ST_K2 and ST_HMUL,
//   a tail passes ST_IDLE and ST_TAIL, and ST_FIN finalizes. A short queue of
//   QueueDepth requests lets item_i keep accepting while the back end works.
//   An empty closing request goes through the queue, ST_IDLE and ST_FIN.
// Reset and stalls:
//   Reset clears the seed to zero, closes any open message, empties the
//   queue and drops a pending result. A stalled receiver holds the result;
//   the back end then waits at finalization and the queue fills behind it.
// ----------------------------------------------------------------------------
module murmurhash2_32 #(
  parameter int unsigned QueueDepth = mh2_pkg::QueueDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mh2_pkg::WordW-1:0] cfg_wdata_i,
  mh2_in_if.sink                    item_i,
  mh2_out_if.source                 result_o
);
  import mh2_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic full;
  logic pop;
  logic nonempty;

  mh2_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .cmd_o       (push_cmd),
    .cmd_push_o  (push),
    .cmd_full_i  (full)
  );

  mh2_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .nonempty_o (nonempty)
  );

  mh2_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .cmd_valid_i (nonempty),
    .cmd_pop_o   (pop),
    .result_o    (result_o)
  );

endmodule

@@ design/mh2_checker.sv @@
// ----------------------------------------------------------------------------
// MurmurHash2 port checker
// Watches the ports of the hasher and checks results against framing.
// ----------------------------------------------------------------------------
module mh2_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      item_valid_i,
  input logic                      item_ready_i,
  input logic [mh2_pkg::CountW-1:0] item_count_i,
  input logic                      item_first_i,
  input logic                      item_last_i,
  input logic                      result_valid_i,
  input logic                      result_ready_i,
  input logic [mh2_pkg::WordW-1:0] result_hash_i
);
  import mh2_pkg::*;

  logic       open_q, open_d;
  logic [3:0] pending_q, pending_d;
  logic       item_acc;
  logic       item_close;
  logic       item_kept;
  logic       result_acc;

  assign item_acc   = item_valid_i && item_ready_i;
  assign item_close = (item_count_i < FullCount) || item_last_i;
  assign item_kept  = item_acc && (item_first_i || open_q);
  assign result_acc = result_valid_i && result_ready_i;

  // Counts closing requests whose hash has not been taken yet.
  always_comb begin
    open_d    = item_kept ? !item_close : open_q;
    pending_d = pending_q;
    if (item_kept && item_close && !result_acc) begin
      pending_d = pending_q + 1'b1;
    end else if (result_acc && !(item_kept && item_close)) begin
      pending_d = pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q    <= 1'b0;
      pending_q <= '0;
    end else begin
      open_q    <= open_d;
      pending_q <= pending_d;
    end
  end

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && !result_ready_i |=> result_valid_i)
    else $error("result dropped while stalled");

  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && !result_ready_i |=> $stable(result_hash_i))
    else $error("result hash changed while stalled");

  a_reset_clears: assert property (@(posedge clk_i)
    !rst_ni |-> !result_valid_i)
    else $error("result valid during reset");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i |-> (pending_q != '0))
    else $error("result without a closed message");

endmodule

bind murmurhash2_32 mh2_checker u_mh2_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .item_valid_i   (item_i.valid),
  .item_ready_i   (item_i.ready),
  .item_count_i   (item_i.byte_count),
  .item_first_i   (item_i.first_item),
  .item_last_i    (item_i.last_item),
  .result_valid_i (result_o.valid),
  .result_ready_i (result_o.ready),
  .result_hash_i  (result_o.hash_value)
);
